FILE: rtl/core/assert_macros.svh
// Assertion macros used by the lennard_jones_pair_terms RTL module of this core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication whose consequent is checked after the delay n.
`define ASSERT_DLY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("delayed implication check failed");

`endif

FILE: rtl/core/ljpt_pkg.sv
// Types, constants and datapath step functions of the Lennard-Jones pair term pipeline.
package ljpt_pkg;

  localparam int unsigned DIST_FRAC_BITS = 16;
  localparam int unsigned NF = 17;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned LATENCY = NF + DIV_STEPS + 2;
  localparam int unsigned SH_E = 19;
  localparam int unsigned SH_F = 20 + DIST_FRAC_BITS;
  localparam int unsigned SH_S = 20 + 2 * DIST_FRAC_BITS;

  localparam logic [1:0] REG_SIGMA   = 2'd0;
  localparam logic [1:0] REG_EPSILON = 2'd1;
  localparam logic [1:0] REG_MIN_DIST = 2'd2;

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  typedef logic [543:0] bw_t;

  typedef struct packed {
    logic               vld;
    logic               close;
    logic [31:0]        r;
    logic [95:0]        s3;
    logic [95:0]        r3;
    logic [191:0]       s6;
    logic [191:0]       r6;
    logic [196:0]       d26;
    logic [194:0]       d7;
    logic [2:0][198:0]  m;
    logic [2:0]         neg;
    logic [383:0]       r12;
    logic [415:0]       r13;
    logic [447:0]       r14;
    logic [2:0][543:0]  p;
  } pre_t;

  typedef struct packed {
    logic [543:0] rem;
    logic [449:0] den;
    logic [63:0]  q;
    logic         neg;
    logic         satp;
  } term_t;

  typedef struct packed {
    logic             vld;
    logic             close;
    term_t [2:0]      t;
  } div_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } res_t;

  // Adds a * b * 2^(32j) to acc using one 32x32 product per word of a.
  function automatic bw_t mac32(input bw_t acc, input bw_t a, input logic [31:0] b,
                                input int unsigned j);
    logic [575:0] ev;
    logic [575:0] od;
    logic [575:0] sum;
    logic [63:0]  pr;
    ev = '0;
    od = '0;
    for (int i = 0; i < 17; i++) begin
      pr = a[32*i +: 32] * b;
      if (i[0]) od[32*i +: 64] = pr;
      else ev[32*i +: 64] = pr;
    end
    sum = (ev + od) << (32 * j);
    return acc + sum[543:0];
  endfunction

  function automatic pre_t front_step(input pre_t x, input int unsigned k,
                                      input logic [31:0] sig, input logic [31:0] eps);
    pre_t        y;
    bw_t         t0;
    int unsigned j;
    y = x;
    if (k == 0) begin
      t0 = mac32('0, bw_t'(sig), sig, 0);
      y.s3 = t0[95:0];
      t0 = mac32('0, bw_t'(x.r), x.r, 0);
      y.r3 = t0[95:0];
    end
    if (k == 1) begin
      t0 = mac32('0, bw_t'(x.s3), sig, 0);
      y.s3 = t0[95:0];
      t0 = mac32('0, bw_t'(x.r3), x.r, 0);
      y.r3 = t0[95:0];
    end
    if (k >= 2 && k <= 4) begin
      j = k - 2;
      t0 = mac32(bw_t'(x.s6), bw_t'(x.s3), x.s3[32*j +: 32], j);
      y.s6 = t0[191:0];
      t0 = mac32(bw_t'(x.r6), bw_t'(x.r3), x.r3[32*j +: 32], j);
      y.r6 = t0[191:0];
    end
    if (k >= 5 && k <= 10) begin
      j = k - 5;
      t0 = mac32(bw_t'(x.r12), bw_t'(x.r6), x.r6[32*j +: 32], j);
      y.r12 = t0[383:0];
    end
    if (k == 5) begin
      y.d26 = ({5'b0, x.s6} << 4) + ({5'b0, x.s6} << 3) + ({5'b0, x.s6} << 1);
      y.d7 = ({3'b0, x.r6} << 3) - {3'b0, x.r6};
    end
    if (k == 6) begin
      y.m[0] = {7'b0, x.s6} - {7'b0, x.r6};
      y.m[1] = {7'b0, x.r6} - ({7'b0, x.s6} << 1);
      y.m[2] = {2'b0, x.d26} - {4'b0, x.d7};
    end
    if (k == 7) begin
      for (int t = 0; t < 3; t++) begin
        y.neg[t] = x.m[t][198];
        y.m[t] = x.m[t][198] ? (~x.m[t] + 199'd1) : x.m[t];
      end
    end
    if (k >= 8 && k <= 13) begin
      j = k - 8;
      for (int t = 0; t < 3; t++) begin
        y.p[t] = mac32(x.p[t], bw_t'(x.m[t]), x.s6[32*j +: 32], j);
      end
    end
    if (k == 11) begin
      t0 = mac32('0, bw_t'(x.r12), x.r, 0);
      y.r13 = t0[415:0];
    end
    if (k == 12) begin
      t0 = mac32('0, bw_t'(x.r13), x.r, 0);
      y.r14 = t0[447:0];
    end
    if (k == 14) begin
      for (int t = 0; t < 3; t++) begin
        y.p[t] = mac32('0, x.p[t], eps, 0);
      end
    end
    if (k == 15) begin
      y.p[1] = x.p[1] + (x.p[1] << 1);
      y.p[2] = x.p[2] + (x.p[2] << 1);
    end
    if (k == 16) begin
      y.p[0] = (x.p[0] << SH_E) + bw_t'(x.r12);
      y.p[1] = (x.p[1] << SH_F) + bw_t'(x.r13);
      y.p[2] = (x.p[2] << SH_S) + bw_t'(x.r14);
    end
    return y;
  endfunction

  function automatic div_t div_entry(input pre_t x);
    div_t y;
    y.vld = x.vld;
    y.close = x.close;
    y.t[0].den = {65'b0, x.r12, 1'b0};
    y.t[1].den = {33'b0, x.r13, 1'b0};
    y.t[2].den = {1'b0, x.r14, 1'b0};
    for (int t = 0; t < 3; t++) begin
      y.t[t].rem = x.p[t];
      y.t[t].q = '0;
      y.t[t].neg = x.neg[t];
      y.t[t].satp = x.p[t] >= ({94'b0, y.t[t].den} << 64);
    end
    return y;
  endfunction

  function automatic div_t div_step(input div_t x, input int unsigned i);
    div_t y;
    bw_t  sub;
    y = x;
    for (int t = 0; t < 3; t++) begin
      sub = {94'b0, x.t[t].den} << i;
      if (!x.t[t].satp && x.t[t].rem >= sub) begin
        y.t[t].rem = x.t[t].rem - sub;
        y.t[t].q[i] = 1'b1;
      end
    end
    return y;
  endfunction

  function automatic res_t clip(input term_t x);
    res_t y;
    y.sat = 1'b0;
    if (x.satp) begin
      y.sat = 1'b1;
      y.val = x.neg ? NEG_MIN : POS_MAX;
    end else if (x.neg) begin
      if (x.q > NEG_MIN) begin
        y.sat = 1'b1;
        y.val = NEG_MIN;
      end else begin
        y.val = ~x.q + 64'd1;
      end
    end else if (x.q[63]) begin
      y.sat = 1'b1;
      y.val = POS_MAX;
    end else begin
      y.val = x.q;
    end
    return y;
  endfunction

endpackage

FILE: rtl/core/lennard_jones_pair_terms.sv
// Lennard-Jones 12-6 pair energy and derivatives as one deep pipeline.
// One distance may start in every cycle and busy never rises; each result
// appears with done exactly 83 cycles after its start, in start order, and must
// be taken in that cycle. The latency is set by the pipeline: 17 stages form
// the powers and numerators one 32-bit word of multiplier per stage, one stage
// checks the range, 64 stages produce one quotient bit each for the three
// exact divisions, and one stage rounds, clips and registers the result.
`include "assert_macros.svh"

module lennard_jones_pair_terms (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        distance,
  output logic               done,
  output logic signed [63:0] energy,
  output logic signed [63:0] first_deriv,
  output logic signed [63:0] second_deriv,
  output logic               too_close,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [31:0] sigma;
  logic [31:0] epsilon;
  logic [31:0] near_limit;

  ljpt_pkg::pre_t fr_in;
  ljpt_pkg::pre_t fr [1:ljpt_pkg::NF];
  ljpt_pkg::div_t dv [0:ljpt_pkg::DIV_STEPS];
  ljpt_pkg::res_t cr [0:2];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma <= 32'd65536;
      epsilon <= 32'd65536;
      near_limit <= 32'd655;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ljpt_pkg::REG_SIGMA:    sigma <= cfg_data;
        ljpt_pkg::REG_EPSILON:  epsilon <= cfg_data;
        ljpt_pkg::REG_MIN_DIST: near_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    fr_in = '0;
    fr_in.vld = start && !busy;
    fr_in.r = distance;
    fr_in.close = (distance == 32'd0) || (distance < near_limit);
  end

  always_ff @(posedge clk) begin
    ljpt_pkg::pre_t fnext;
    ljpt_pkg::div_t dnext;
    fnext = ljpt_pkg::front_step(fr_in, 0, sigma, epsilon);
    fnext.vld = fnext.vld && !rst;
    fr[1] <= fnext;
    for (int k = 1; k < ljpt_pkg::NF; k++) begin
      fnext = ljpt_pkg::front_step(fr[k], k, sigma, epsilon);
      fnext.vld = fnext.vld && !rst;
      fr[k+1] <= fnext;
    end
    dnext = ljpt_pkg::div_entry(fr[ljpt_pkg::NF]);
    dnext.vld = dnext.vld && !rst;
    dv[0] <= dnext;
    for (int s = 0; s < ljpt_pkg::DIV_STEPS; s++) begin
      dnext = ljpt_pkg::div_step(dv[s], ljpt_pkg::DIV_STEPS - 1 - s);
      dnext.vld = dnext.vld && !rst;
      dv[s+1] <= dnext;
    end
  end

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      cr[t] = ljpt_pkg::clip(dv[ljpt_pkg::DIV_STEPS].t[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[ljpt_pkg::DIV_STEPS].vld;
    end
    if (dv[ljpt_pkg::DIV_STEPS].close) begin
      energy <= '0;
      first_deriv <= '0;
      second_deriv <= '0;
      too_close <= 1'b1;
      saturated <= 1'b0;
    end else begin
      energy <= cr[0].val;
      first_deriv <= cr[1].val;
      second_deriv <= cr[2].val;
      too_close <= 1'b0;
      saturated <= cr[0].sat || cr[1].sat || cr[2].sat;
    end
  end

  `ASSERT_DLY(a_latency, start && !busy, ljpt_pkg::LATENCY, done)
  `ASSERT_IMP(a_no_spurious, done, $past(start, ljpt_pkg::LATENCY))
  `ASSERT_IMP(a_close_zero, done && too_close, !(|{energy, first_deriv, second_deriv, saturated}))

endmodule

FILE: tb/tb_lennard_jones_pair_terms.sv
// Self-checking testbench of the Lennard-Jones pair term pipeline.
`timescale 1ns / 100ps

module tb_lennard_jones_pair_terms;

  typedef logic [639:0] wide_t;

  typedef struct packed {
    logic signed [63:0] energy;
    logic signed [63:0] first_deriv;
    logic signed [63:0] second_deriv;
    logic               too_close;
    logic               saturated;
  } terms_t;

  typedef struct {
    logic [31:0] sig;
    logic [31:0] eps;
    logic [31:0] min_dist;
    logic [31:0] pair_r;
    bit          typed;
    terms_t      want;
  } row_t;

  localparam int unsigned CYCLE_LIMIT = 300000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [31:0]        distance = '0;
  logic               done;
  logic signed [63:0] energy;
  logic signed [63:0] first_deriv;
  logic signed [63:0] second_deriv;
  logic               too_close;
  logic               saturated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = ljpt_pkg::REG_SIGMA;
  logic [31:0]        cfg_data = '0;

  logic [31:0] sigma_q = 32'd65536;
  logic [31:0] eps_q = 32'd65536;
  logic [31:0] min_q = 32'd655;

  terms_t      pending_terms[$];
  terms_t      typed_terms[$];
  bit          typed_flags[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  int unsigned sender_idle = 0;
  bit          use_typed = 1'b0;
  terms_t      typed_want = '0;

  lennard_jones_pair_terms u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .distance(distance),
    .done(done), .energy(energy), .first_deriv(first_deriv),
    .second_deriv(second_deriv), .too_close(too_close), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] lj_term(input int unsigned factor, input int unsigned shift,
                                          input logic [31:0] eps, input wide_t s6,
                                          input wide_t a, input wide_t b, input wide_t den,
                                          inout logic sat);
    logic        neg;
    wide_t       mag;
    wide_t       num;
    wide_t       den2;
    logic [63:0] q;
    neg = a < b;
    mag = neg ? b - a : a - b;
    num = ((s6 * mag * wide_t'(factor) * wide_t'(eps)) << shift);
    num = (num << 1) + den;
    den2 = den << 1;
    if (num >= (den2 << 64)) begin
      sat = 1'b1;
      return neg ? ljpt_pkg::NEG_MIN : ljpt_pkg::POS_MAX;
    end
    q = 64'(num / den2);
    if (neg) begin
      if (q > ljpt_pkg::NEG_MIN) begin
        sat = 1'b1;
        return ljpt_pkg::NEG_MIN;
      end
      return ~q + 64'd1;
    end
    if (q[63]) begin
      sat = 1'b1;
      return ljpt_pkg::POS_MAX;
    end
    return q;
  endfunction

  function automatic terms_t lj_terms(input logic [31:0] r);
    terms_t t;
    wide_t  s6;
    wide_t  r6;
    wide_t  r12;
    logic   sat;
    t = '0;
    if (r == 0 || r < min_q) begin
      t.too_close = 1'b1;
      return t;
    end
    sat = 1'b0;
    s6 = wide_t'(sigma_q) * sigma_q * sigma_q;
    s6 = s6 * s6;
    r6 = wide_t'(r) * r * r;
    r6 = r6 * r6;
    r12 = r6 * r6;
    t.energy = lj_term(4, 16, eps_q, s6, s6, r6, r12, sat);
    t.first_deriv = lj_term(24, 16 + ljpt_pkg::DIST_FRAC_BITS, eps_q, s6, r6, s6 << 1,
                            r12 * r, sat);
    t.second_deriv = lj_term(24, 16 + 2 * ljpt_pkg::DIST_FRAC_BITS, eps_q, s6, s6 * 26,
                             r6 * 7, r12 * r * r, sat);
    t.saturated = sat;
    return t;
  endfunction

  // Accepted beats are predicted at the edge that accepts them.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        ljpt_pkg::REG_SIGMA:    sigma_q <= cfg_data;
        ljpt_pkg::REG_EPSILON:  eps_q <= cfg_data;
        ljpt_pkg::REG_MIN_DIST: min_q <= cfg_data;
        default: ;
      endcase
    end
    if (!rst && start && !busy) begin
      pending_terms.push_back(lj_terms(distance));
      typed_flags.push_back(use_typed);
      typed_terms.push_back(typed_want);
    end
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (pending_terms.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        terms_t w;
        w = typed_flags[0] ? typed_terms[0] : pending_terms[0];
        if (typed_flags[0] && typed_terms[0] !== pending_terms[0] && mismatches < 10)
          $display("predictor disagrees with typed expectation");
        if (energy !== w.energy || first_deriv !== w.first_deriv ||
            second_deriv !== w.second_deriv || too_close !== w.too_close ||
            saturated !== w.saturated) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp %h %h %h %b %b got %h %h %h %b %b",
                     w.energy, w.first_deriv, w.second_deriv, w.too_close, w.saturated,
                     energy, first_deriv, second_deriv, too_close, saturated);
        end
        void'(pending_terms.pop_front());
        void'(typed_flags.pop_front());
        void'(typed_terms.pop_front());
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lennard_jones_pair_terms verification failed");
      $finish;
    end
  end

  task automatic drain_and_settle();
    start <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (ljpt_pkg::LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [31:0] s, input logic [31:0] e, input logic [31:0] m);
    drain_and_settle();
    write_reg(ljpt_pkg::REG_SIGMA, s);
    write_reg(ljpt_pkg::REG_EPSILON, e);
    write_reg(ljpt_pkg::REG_MIN_DIST, m);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_distance(input logic [31:0] d);
    if ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    distance <= d;
    do @(posedge clk); while (busy);
  endtask

  function automatic row_t mk(input logic [31:0] s, input logic [31:0] e,
                              input logic [31:0] m, input logic [31:0] d, input bit typed,
                              input logic [63:0] en, input logic [63:0] fd,
                              input logic [63:0] sd, input logic tc);
    row_t r;
    r.sig = s; r.eps = e; r.min_dist = m; r.pair_r = d; r.typed = typed;
    r.want = '{en, fd, sd, tc, 1'b0};
    return r;
  endfunction

  function automatic logic [31:0] pick_distance();
    logic [63:0] d;
    case ($urandom_range(9))
      0: d = $urandom();
      1: d = $urandom_range(0, 2 * min_q + 1);
      default: d = 64'(sigma_q) + $urandom_range(0, 2 * sigma_q) - sigma_q / 8;
    endcase
    return d > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : d[31:0];
  endfunction

  initial begin
    row_t        rows[$];
    logic [31:0] s;
    logic [31:0] e;
    logic [31:0] m;
    logic [31:0] cs;
    logic [31:0] ce;
    logic [31:0] cm;
    int unsigned sent;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back(mk(65536, 65536, 655, 0, 1, 0, 0, 0, 1));
    rows.push_back(mk(65536, 65536, 655, 654, 1, 0, 0, 0, 1));
    rows.push_back(mk(65536, 65536, 655, 655, 0, 0, 0, 0, 0));
    rows.push_back(mk(65536, 65536, 655, 65536, 1, 0, -(64'd24 << 32), 64'd456 << 32, 0));
    rows.push_back(mk(65536, 65536, 655, 32'h8000_0000, 0, 0, 0, 0, 0));
    rows.push_back(mk(65536, 65536, 655, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    rows.push_back(mk(65536, 65536, 655, 85000, 0, 0, 0, 0, 0));
    rows.push_back(mk(65536, 65536, 0, 0, 1, 0, 0, 0, 1));
    rows.push_back(mk(65536, 65536, 0, 1, 0, 0, 0, 0, 0));
    rows.push_back(mk(0, 65536, 655, 65536, 1, 0, 0, 0, 0));
    rows.push_back(mk(32'hFFFF_FFFF, 0, 655, 70000, 1, 0, 0, 0, 0));
    rows.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                      1, 0, 0, 0, 1));
    rows.push_back(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      0, 0, 0, 0, 0));
    rows.push_back(mk(1, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 0, 0));
    rows.push_back(mk(1, 32'hFFFF_FFFF, 1, 2, 0, 0, 0, 0, 0));
    rows.push_back(mk(32'h0003_0000, 32'h0000_8000, 32'h0001_0000, 32'h0003_5000,
                      0, 0, 0, 0, 0));

    cs = 65536; ce = 65536; cm = 655;
    foreach (rows[i]) begin
      if (rows[i].sig != cs || rows[i].eps != ce || rows[i].min_dist != cm) begin
        set_config(rows[i].sig, rows[i].eps, rows[i].min_dist);
        cs = rows[i].sig; ce = rows[i].eps; cm = rows[i].min_dist;
      end
      start <= 1'b1;
      distance <= rows[i].pair_r;
      use_typed <= rows[i].typed;
      typed_want <= rows[i].want;
      do @(posedge clk); while (busy);
    end
    start <= 1'b0;
    use_typed <= 1'b0;

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle = (phase == 0) ? 21 : (phase == 1) ? 86 : 0;
      for (int set = 0; set < 4; set++) begin
        s = $urandom_range(32'h0000_8000, 32'h0004_0000);
        e = (set == 0) ? $urandom() : $urandom_range(1, 32'h0010_0000);
        m = $urandom_range(1, s / 2);
        set_config(s, e, m);
        for (int n = 0; n < 46; n++) begin
          send_distance(pick_distance());
          sent++;
          if (phase == 0 && set == 1 && n == 20) begin
            start <= 1'b0;
            @(posedge clk);
            while (pending_terms.size() != 0) @(posedge clk);
          end
        end
      end
    end

    start <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (ljpt_pkg::LATENCY + 5) @(posedge clk);
    $display("Covered %0d random distances over 12 register settings plus directed edge cases,",
             sent);
    $display("with %0d result beats checked and %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("lennard_jones_pair_terms verification clean");
    end else begin
      $display("lennard_jones_pair_terms verification failed");
    end
    $finish;
  end

endmodule
